// ===== rtl/shg_pkg.sv =====
`default_nettype none
package shg_pkg;

	localparam int MAX_POINTS_DEF   = 1024;
	localparam int GRID_DIM_MAX_DEF = 64;
	localparam int BUCKET_SLOTS_DEF = 16;

	localparam int NEARBY_KEYS = 4;
	localparam int KEY_W       = 16; // wide enough for a 256 by 256 grid
	localparam int QUEUE_DEPTH = 2;
	localparam int MAX_RESULTS = 64;
	localparam int HIT_CNT_W   = $clog2(MAX_RESULTS + 1);

	localparam int SPACING_W = 31;
	localparam int RES_W     = 7;
	localparam int CFG_IDX_W = 2;

	localparam int DIV_NUM_W = 34;
	localparam int DIV_DEN_W = 31;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_SPACING = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION_X = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION_Y = 2'd2;

	typedef enum logic [1:0] {
		OP_CLEAR     = 2'd0,
		OP_ADD       = 2'd1,
		OP_QUERY_ALL = 2'd2,
		OP_QUERY_ANY = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_STORE_FULL  = 2'd1,
		ST_BUCKET_FULL = 2'd2
	} status_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] x_coord;
		logic signed [31:0] y_coord;
		logic [30:0]        radius;
	} in_t;

	typedef struct packed {
		logic [9:0]         point_index;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic               hit;
		status_t            status;
		logic               last;
	} out_t;

	typedef struct packed {
		op_t                                op;
		logic signed [31:0]                 x;
		logic signed [31:0]                 y;
		logic [30:0]                        radius;
		logic [NEARBY_KEYS-1:0][KEY_W-1:0]  keys;
	} cmd_t;

endpackage
`default_nettype wire

// ===== rtl/shg_div.sv =====
`default_nettype none
module shg_div import shg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic                 done,
	output logic [DIV_NUM_W-1:0] quo,
	output logic [DIV_DEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 ge;

	assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
			rem_q <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

// ===== rtl/shg_front.sv =====
`default_nettype none
module shg_front import shg_pkg::*; #(
	parameter int GRID_DIM_MAX = GRID_DIM_MAX_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_data,
	input  logic [SPACING_W-1:0] grid_spacing,
	input  logic [RES_W-1:0]     resolution_x,
	input  logic [RES_W-1:0]     resolution_y,
	input  logic                 hold,
	input  logic                 q_full,
	output logic                 q_push,
	output cmd_t                 q_data
);

	localparam int DIM_W = $clog2(GRID_DIM_MAX + 1);
	localparam int WI_W  = $clog2(GRID_DIM_MAX);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	function automatic logic [DIM_W-1:0] eff_res(input logic [RES_W-1:0] r);
		logic [RES_W+DIM_W-1:0] e;
		e = {{DIM_W{1'b0}}, r};
		if (r == '0)
			return DIM_W'(1);
		if (e > (RES_W+DIM_W)'(GRID_DIM_MAX))
			return DIM_W'(GRID_DIM_MAX);
		return e[DIM_W-1:0];
	endfunction

	function automatic logic [DIV_NUM_W-1:0] abs_n(input logic [DIV_NUM_W-1:0] v);
		return v[DIV_NUM_W-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [WI_W-1:0] nb_step(input logic [WI_W-1:0] w,
			input logic [DIM_W-1:0] r, input logic up);
		logic [DIM_W-1:0] t;
		t = r - 1'b1;
		if (up)
			return (DIM_W'(w) + 1'b1 == r) ? '0 : w + 1'b1;
		return (w == '0) ? t[WI_W-1:0] : w - 1'b1;
	endfunction

	function automatic logic [KEY_W-1:0] key_of(input logic [WI_W-1:0] wx,
			input logic [WI_W-1:0] wy, input logic [DIM_W-1:0] r);
		return KEY_W'(wy) * KEY_W'(r) + KEY_W'(wx);
	endfunction

	fstate_t              st_q;
	logic [1:0]           step_q;
	logic                 start_q;
	in_t                  in_q;
	logic [DIV_NUM_W-1:0] bx_q, by_q;
	logic [SPACING_W-1:0] remx_q, remy_q;
	logic [WI_W-1:0]      wx_q, wy_q;

	logic [SPACING_W-1:0] sp;
	logic [DIM_W-1:0]     rx, ry, wres;
	logic [DIV_NUM_W-1:0] div_num, div_quo, fq;
	logic [DIV_DEN_W-1:0] div_den, div_rem, frem;
	logic                 div_done, neg, rz, wneg, upx, upy;
	logic [WI_W-1:0]      m, wv, wx2, wy2;
	logic [DIM_W-1:0]     wt;

	assign sp = (grid_spacing == '0) ? SPACING_W'(1) : grid_spacing;
	assign rx = eff_res(resolution_x);
	assign ry = eff_res(resolution_y);

	always_comb begin
		case (step_q)
			2'd0:    div_num = abs_n({{2{in_q.x_coord[31]}}, in_q.x_coord});
			2'd1:    div_num = abs_n({{2{in_q.y_coord[31]}}, in_q.y_coord});
			2'd2:    div_num = abs_n(bx_q);
			default: div_num = abs_n(by_q);
		endcase
	end

	assign wres    = step_q[0] ? ry : rx;
	assign div_den = step_q[1] ? DIV_DEN_W'(wres) : sp;

	shg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// floor division from the magnitude result
	assign neg  = step_q[0] ? in_q.y_coord[31] : in_q.x_coord[31];
	assign rz   = div_rem == '0;
	assign fq   = neg ? (rz ? (~div_quo + 1'b1) : ~div_quo) : div_quo;
	assign frem = (neg && !rz) ? sp - div_rem : div_rem;

	// wrap into the grid
	assign wneg = step_q[0] ? by_q[DIV_NUM_W-1] : bx_q[DIV_NUM_W-1];
	assign m    = div_rem[WI_W-1:0];
	assign wt   = wres - DIM_W'(m);
	assign wv   = (wneg && m != '0) ? wt[WI_W-1:0] : m;

	assign upx = {remx_q, 1'b0} >= {1'b0, sp};
	assign upy = {remy_q, 1'b0} >= {1'b0, sp};
	assign wx2 = nb_step(wx_q, rx, upx);
	assign wy2 = nb_step(wy_q, ry, upy);

	always_comb begin
		q_data         = '0;
		q_data.op      = in_q.op;
		q_data.x       = in_q.x_coord;
		q_data.y       = in_q.y_coord;
		q_data.radius  = in_q.radius;
		q_data.keys[0] = key_of(wx_q, wy_q, rx);
		q_data.keys[1] = key_of(wx_q, wy2, rx);
		q_data.keys[2] = key_of(wx2, wy_q, rx);
		q_data.keys[3] = key_of(wx2, wy2, rx);
	end

	assign q_push   = (st_q == F_PUSH) && !q_full;
	assign in_stall = (st_q != F_IDLE) || hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= F_IDLE;
			step_q  <= '0;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (st_q)
				F_IDLE: begin
					if (in_valid && !in_stall) begin
						step_q <= '0;
						if (in_data.op == OP_CLEAR) begin
							st_q <= F_PUSH;
						end else begin
							start_q <= 1'b1;
							st_q    <= F_DIV;
						end
					end
				end
				F_DIV: begin
					if (div_done) begin
						if (step_q == 2'd3) begin
							st_q <= F_PUSH;
						end else begin
							step_q  <= step_q + 1'b1;
							start_q <= 1'b1;
						end
					end
				end
				F_PUSH: begin
					if (!q_full)
						st_q <= F_IDLE;
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == F_IDLE && in_valid && !in_stall)
			in_q <= in_data;
		if (div_done) begin
			case (step_q)
				2'd0: begin
					bx_q   <= fq;
					remx_q <= frem;
				end
				2'd1: begin
					by_q   <= fq;
					remy_q <= frem;
				end
				2'd2:    wx_q <= wv;
				default: wy_q <= wv;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/shg_fifo.sv =====
`default_nettype none
module shg_fifo import shg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t pop_data,
	output logic empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full     = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= nxt(wr_q);
			if (pop)
				rd_q <= nxt(rd_q);
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

endmodule
`default_nettype wire

// ===== rtl/shg_back.sv =====
`default_nettype none
module shg_back import shg_pkg::*; #(
	parameter int MAX_POINTS   = MAX_POINTS_DEF,
	parameter int GRID_DIM_MAX = GRID_DIM_MAX_DEF,
	parameter int BUCKET_SLOTS = BUCKET_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  cmd_t q_data,
	output logic q_pop,
	output logic init_busy,
	output logic out_valid,
	input  logic out_stall,
	output out_t out_data
);

	localparam int NB     = GRID_DIM_MAX * GRID_DIM_MAX;
	localparam int BK_W   = $clog2(NB);
	localparam int NSLOT  = NB * BUCKET_SLOTS;
	localparam int SA_W   = $clog2(NSLOT);
	localparam int PI_W   = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int FILL_W = $clog2(BUCKET_SLOTS + 1);
	localparam int K_W    = $clog2(NEARBY_KEYS);

	typedef enum logic [11:0] {
		B_SWEEP   = 12'b000000000001,
		B_CLR_OUT = 12'b000000000010,
		B_IDLE    = 12'b000000000100,
		B_ADD_RD  = 12'b000000001000,
		B_ADD_CHK = 12'b000000010000,
		B_Q_FILL  = 12'b000000100000,
		B_Q_FILLW = 12'b000001000000,
		B_Q_SLOT  = 12'b000010000000,
		B_Q_PT    = 12'b000100000000,
		B_Q_MUL   = 12'b001000000000,
		B_Q_CMP   = 12'b010000000000,
		B_Q_END   = 12'b100000000000
	} bstate_t;

	function automatic logic [9:0] idx10(input logic [PI_W-1:0] i);
		logic [PI_W+9:0] e;
		e = {10'b0, i};
		return e[9:0];
	endfunction

	bstate_t              state_q;
	logic                 init_q, emit_clr_q;
	logic [BK_W-1:0]      sw_q;
	cmd_t                 cmd_q;
	logic [K_W-1:0]       k_q;
	logic [FILL_W-1:0]    j_q;
	logic [HIT_CNT_W-1:0] n_q;
	logic [CNT_W-1:0]     pc_q;
	logic [FILL_W-1:0]    fill_rd_q;
	logic [PI_W-1:0]      slot_rd_q, idx_q;
	logic [63:0]          pt_rd_q;
	logic signed [31:0]   px_q, py_q;
	logic                 far_q;
	logic [61:0]          x2_q, y2_q, r2_q;
	logic                 out_valid_q;
	out_t                 out_q;

	logic [FILL_W-1:0] fill_mem [NB];
	logic [PI_W-1:0]   slot_mem [NSLOT];
	logic [63:0]       pt_mem   [MAX_POINTS];

	logic [BK_W-1:0]   cur_key, fill_waddr;
	logic [SA_W-1:0]   slot_raddr, slot_waddr;
	logic              fill_we, commit, store_full, bucket_full, out_free, ld, hit;
	logic              last_slot, last_key;
	logic [FILL_W-1:0] fill_wdata;
	out_t              ld_data;
	logic signed [32:0] dx, dy;
	logic [32:0]       ax, ay;
	logic [62:0]       dsum;

	assign cur_key    = cmd_q.keys[k_q][BK_W-1:0];
	assign slot_raddr = SA_W'(cur_key) * SA_W'(BUCKET_SLOTS) + SA_W'(j_q);
	assign slot_waddr = SA_W'(cur_key) * SA_W'(BUCKET_SLOTS) + SA_W'(fill_rd_q);

	assign store_full  = pc_q == CNT_W'(MAX_POINTS);
	assign bucket_full = fill_rd_q >= FILL_W'(BUCKET_SLOTS);
	assign out_free    = !out_valid_q || !out_stall;
	assign commit      = (state_q == B_ADD_CHK) && out_free && !store_full && !bucket_full;

	assign fill_we    = (state_q == B_SWEEP) || commit;
	assign fill_waddr = (state_q == B_SWEEP) ? sw_q : cur_key;
	assign fill_wdata = (state_q == B_SWEEP) ? '0 : fill_rd_q + 1'b1;

	assign last_slot = ({1'b0, j_q} + 1'b1) >= {1'b0, fill_rd_q};
	assign last_key  = k_q == K_W'(NEARBY_KEYS - 1);

	// squares only matter once each axis distance is within the radius
	assign dx = {pt_rd_q[63], pt_rd_q[63:32]} - {cmd_q.x[31], cmd_q.x};
	assign dy = {pt_rd_q[31], pt_rd_q[31:0]} - {cmd_q.y[31], cmd_q.y};
	assign ax = dx[32] ? 33'(-dx) : 33'(dx);
	assign ay = dy[32] ? 33'(-dy) : 33'(dy);
	assign dsum = {1'b0, x2_q} + {1'b0, y2_q};
	assign hit  = !far_q && (dsum <= {1'b0, r2_q});

	assign q_pop     = (state_q == B_IDLE) && !q_empty;
	assign init_busy = init_q;

	always_comb begin
		ld      = 1'b0;
		ld_data = '0;
		case (state_q)
			B_CLR_OUT, B_Q_END: begin
				ld           = out_free;
				ld_data.last = 1'b1;
			end
			B_ADD_CHK: begin
				ld              = out_free;
				ld_data.point_x = cmd_q.x;
				ld_data.point_y = cmd_q.y;
				ld_data.last    = 1'b1;
				if (store_full)
					ld_data.status = ST_STORE_FULL;
				else if (bucket_full)
					ld_data.status = ST_BUCKET_FULL;
				else
					ld_data.point_index = idx10(pc_q[PI_W-1:0]);
			end
			B_Q_CMP: begin
				ld                  = hit && out_free;
				ld_data.point_index = idx10(idx_q);
				ld_data.point_x     = px_q;
				ld_data.point_y     = py_q;
				ld_data.hit         = 1'b1;
				ld_data.last        = (cmd_q.op == OP_QUERY_ANY) ||
				                      (n_q == HIT_CNT_W'(MAX_RESULTS - 1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_SWEEP;
			init_q      <= 1'b1;
			emit_clr_q  <= 1'b0;
			sw_q        <= '0;
			pc_q        <= '0;
			k_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				B_SWEEP: begin
					sw_q <= sw_q + 1'b1;
					if (sw_q == BK_W'(NB - 1)) begin
						sw_q    <= '0;
						init_q  <= 1'b0;
						state_q <= emit_clr_q ? B_CLR_OUT : B_IDLE;
					end
				end
				B_CLR_OUT: begin
					if (out_free)
						state_q <= B_IDLE;
				end
				B_IDLE: begin
					if (!q_empty) begin
						k_q <= '0;
						j_q <= '0;
						n_q <= '0;
						unique case (q_data.op)
							OP_CLEAR: begin
								emit_clr_q <= 1'b1;
								pc_q       <= '0;
								state_q    <= B_SWEEP;
							end
							OP_ADD:                     state_q <= B_ADD_RD;
							OP_QUERY_ALL, OP_QUERY_ANY: state_q <= B_Q_FILL;
							default:                    state_q <= B_IDLE;
						endcase
					end
				end
				B_ADD_RD: state_q <= B_ADD_CHK;
				B_ADD_CHK: begin
					if (out_free) begin
						if (commit)
							pc_q <= pc_q + 1'b1;
						state_q <= B_IDLE;
					end
				end
				B_Q_FILL: state_q <= B_Q_FILLW;
				B_Q_FILLW: begin
					j_q <= '0;
					if (fill_rd_q != '0) begin
						state_q <= B_Q_SLOT;
					end else if (last_key) begin
						state_q <= B_Q_END;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= B_Q_FILL;
					end
				end
				B_Q_SLOT: state_q <= B_Q_PT;
				B_Q_PT:   state_q <= B_Q_MUL;
				B_Q_MUL:  state_q <= B_Q_CMP;
				B_Q_CMP: begin
					if (!hit || out_free) begin
						if (hit && ld_data.last) begin
							state_q <= B_IDLE;
						end else begin
							if (hit)
								n_q <= n_q + 1'b1;
							if (!last_slot) begin
								j_q     <= j_q + 1'b1;
								state_q <= B_Q_SLOT;
							end else if (last_key) begin
								state_q <= B_Q_END;
							end else begin
								k_q     <= k_q + 1'b1;
								state_q <= B_Q_FILL;
							end
						end
					end
				end
				B_Q_END: begin
					if (out_free)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cmd_q <= q_data;
		if (state_q == B_Q_PT)
			idx_q <= slot_rd_q;
		if (state_q == B_Q_MUL) begin
			px_q  <= pt_rd_q[63:32];
			py_q  <= pt_rd_q[31:0];
			far_q <= (ax > {2'b0, cmd_q.radius}) || (ay > {2'b0, cmd_q.radius});
			x2_q  <= 62'(ax[30:0]) * 62'(ax[30:0]);
			y2_q  <= 62'(ay[30:0]) * 62'(ay[30:0]);
			r2_q  <= 62'(cmd_q.radius) * 62'(cmd_q.radius);
		end
		if (ld)
			out_q <= ld_data;
	end

	always_ff @(posedge clk) begin
		if (fill_we)
			fill_mem[fill_waddr] <= fill_wdata;
		fill_rd_q <= fill_mem[cur_key];
	end

	always_ff @(posedge clk) begin
		if (commit)
			slot_mem[slot_waddr] <= pc_q[PI_W-1:0];
		slot_rd_q <= slot_mem[slot_raddr];
	end

	always_ff @(posedge clk) begin
		if (commit)
			pt_mem[pc_q[PI_W-1:0]] <= {cmd_q.x, cmd_q.y};
		pt_rd_q <= pt_mem[slot_rd_q];
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

// ===== rtl/spatial_hash_grid_neighbor_search_core.sv =====
// 2-D spatial hash grid, Q16.16 points, neighbour search over four buckets.
// Input channel in_valid/in_stall/in_data carries an op (clear, add, query
// all, query any), a point or query origin, and a radius. Output channel
// out_valid/out_stall/out_data returns one result per clear or add, one per
// query any, and for query all one result per hit then a terminator (the 64th
// hit closes the query itself). The user must write registers through
// cfg_we/cfg_index/cfg_data only while the block is idle (not enforced).
// The front end turns each add or query into bucket keys with a shared one-bit-
// per-cycle divider in four passes.
// The back end reads then checks each add. A query reads each bucket's fill,
// then takes each candidate point through slot, point, multiply and compare;
// a clear sweeps every fill entry. A two-entry queue sits between the ends.
// Reset clears all control state and then sweeps the bucket fill memory with
// in_stall held high.
// While out_stall is high the result register holds its transfer and the
// back end waits; the front end keeps taking items until the queue fills.
`default_nettype none
module spatial_hash_grid_neighbor_search_core import shg_pkg::*; #(
	parameter int MAX_POINTS   = MAX_POINTS_DEF,
	parameter int GRID_DIM_MAX = GRID_DIM_MAX_DEF,
	parameter int BUCKET_SLOTS = BUCKET_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SPACING_W-1:0] cfg_data
);

	logic [SPACING_W-1:0] grid_spacing_q;
	logic [RES_W-1:0]     resolution_x_q, resolution_y_q;
	logic                 q_full, q_empty, q_push, q_pop, init_busy;
	cmd_t                 push_cmd, pop_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_spacing_q <= SPACING_W'(65536);
			resolution_x_q <= RES_W'(64);
			resolution_y_q <= RES_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_SPACING: grid_spacing_q <= cfg_data;
				REG_RESOLUTION_X: resolution_x_q <= cfg_data[RES_W-1:0];
				REG_RESOLUTION_Y: resolution_y_q <= cfg_data[RES_W-1:0];
				default: ;
			endcase
		end
	end

	shg_front #(
		.GRID_DIM_MAX (GRID_DIM_MAX)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.grid_spacing (grid_spacing_q),
		.resolution_x (resolution_x_q),
		.resolution_y (resolution_y_q),
		.hold         (init_busy),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (push_cmd)
	);

	shg_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_cmd),
		.empty     (q_empty)
	);

	shg_back #(
		.MAX_POINTS   (MAX_POINTS),
		.GRID_DIM_MAX (GRID_DIM_MAX),
		.BUCKET_SLOTS (BUCKET_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (pop_cmd),
		.q_pop     (q_pop),
		.init_busy (init_busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ===== tb/sv/spatial_hash_grid_neighbor_search_checker.sv =====
`timescale 1ns / 100ps
module spatial_hash_grid_neighbor_search_checker import shg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  in_t                  in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  out_t                 out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SPACING_W-1:0] cfg_data,
	output int                   errors,
	output int                   pending
);
	localparam int NPTS  = MAX_POINTS_DEF;
	localparam int GDIM  = GRID_DIM_MAX_DEF;
	localparam int SLOTS = BUCKET_SLOTS_DEF;

	logic [30:0] spacing;
	logic [6:0]  res_x, res_y;
	logic signed [31:0] pt_x [NPTS];
	logic signed [31:0] pt_y [NPTS];
	int          npoints;
	int          fill [GDIM*GDIM];
	int          slot [GDIM*GDIM][SLOTS];
	out_t        expected_q [$];

	assign pending = expected_q.size();

	function automatic longint eff_res(logic [6:0] r);
		if (r == 0) return 1;
		if (r > GDIM) return GDIM;
		return r;
	endfunction

	function automatic longint cell_of(longint c, longint s, output longint rem);
		longint q;
		q = c / s;
		rem = c - q * s;
		if (rem < 0) begin
			q = q - 1;
			rem = rem + s;
		end
		return q;
	endfunction

	function automatic int bucket_key(longint bx, longint by);
		longint rx, ry, wx, wy;
		rx = eff_res(res_x);
		ry = eff_res(res_y);
		wx = bx % rx;
		wy = by % ry;
		if (wx < 0) wx += rx;
		if (wy < 0) wy += ry;
		return int'(wy * rx + wx);
	endfunction

	function automatic bit in_range(int idx, longint ox, longint oy, longint unsigned r2);
		longint dx, dy;
		longint unsigned x2, y2;
		dx = longint'(pt_x[idx]) - ox;
		dy = longint'(pt_y[idx]) - oy;
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		x2 = longint'(dx) * longint'(dx);
		y2 = longint'(dy) * longint'(dy);
		if (x2 > r2 || y2 > r2) return 0;
		return (x2 + y2) <= r2;
	endfunction

	task automatic predict_results(in_t it);
		longint s, ox, oy, rx, ry, bx, by, sx, sy;
		longint unsigned r2;
		int    keys [4];
		int    key, idx, n;
		out_t  r;
		r = '0;
		ox = longint'(it.x_coord);
		oy = longint'(it.y_coord);
		s = (spacing == 0) ? 1 : longint'(spacing);
		r2 = longint'(it.radius) * longint'(it.radius);
		bx = cell_of(ox, s, rx);
		by = cell_of(oy, s, ry);
		case (it.op)
			OP_CLEAR: begin
				npoints = 0;
				foreach (fill[k]) fill[k] = 0;
				r.last = 1;
				expected_q = {expected_q, r};
			end
			OP_ADD: begin
				key = bucket_key(bx, by);
				r.point_x = it.x_coord;
				r.point_y = it.y_coord;
				r.last = 1;
				if (npoints >= NPTS) r.status = ST_STORE_FULL;
				else if (fill[key] >= SLOTS) r.status = ST_BUCKET_FULL;
				else begin
					pt_x[npoints] = it.x_coord;
					pt_y[npoints] = it.y_coord;
					slot[key][fill[key]] = npoints;
					fill[key]++;
					r.point_index = npoints[9:0];
					npoints++;
				end
				expected_q = {expected_q, r};
			end
			default: begin
				sx = (2 * rx >= s) ? 1 : -1;
				sy = (2 * ry >= s) ? 1 : -1;
				keys[0] = bucket_key(bx, by);
				keys[1] = bucket_key(bx, by + sy);
				keys[2] = bucket_key(bx + sx, by);
				keys[3] = bucket_key(bx + sx, by + sy);
				n = 0;
				for (int k = 0; k < 4; k++) begin
					key = keys[k];
					for (int j = 0; j < fill[key]; j++) begin
						idx = slot[key][j];
						if (in_range(idx, ox, oy, r2) && n < 64) begin
							r = '0;
							r.point_index = idx[9:0];
							r.point_x = pt_x[idx];
							r.point_y = pt_y[idx];
							r.hit = 1;
							if (it.op == OP_QUERY_ANY) begin
								if (n == 0) begin
									r.last = 1;
									expected_q = {expected_q, r};
								end
							end else begin
								expected_q = {expected_q, r};
							end
							n++;
						end
					end
				end
				if (it.op == OP_QUERY_ANY) begin
					if (n == 0) begin
						r = '0;
						r.last = 1;
						expected_q = {expected_q, r};
					end
				end else if (n >= 64) begin
					expected_q[$].last = 1;
				end else begin
					r = '0;
					r.last = 1;
					expected_q = {expected_q, r};
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			spacing = 31'd65536;
			res_x = 7'd64;
			res_y = 7'd64;
			npoints = 0;
			foreach (fill[k]) fill[k] = 0;
			expected_q.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GRID_SPACING: spacing = cfg_data;
					REG_RESOLUTION_X: res_x = cfg_data[6:0];
					REG_RESOLUTION_Y: res_y = cfg_data[6:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_data);
					errors++;
				end else begin
					want = expected_q.pop_front();
					if (want.point_index !== out_data.point_index
							|| want.point_x !== out_data.point_x
							|| want.point_y !== out_data.point_y
							|| want.hit !== out_data.hit
							|| want.status !== out_data.status
							|| want.last !== out_data.last) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, out_data);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall)
				predict_results(in_data);
		end
	end
endmodule

// ===== tb/sv/spatial_hash_grid_neighbor_search_core_test.sv =====
`timescale 1ns / 100ps
module spatial_hash_grid_neighbor_search_core_test;
	import shg_pkg::*;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 in_valid = 0;
	logic                 in_stall;
	in_t                  in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 0;
	out_t                 out_data;
	logic                 cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_GRID_SPACING;
	logic [SPACING_W-1:0] cfg_data = '0;
	int                   errors, pending;
	int                   send_idle, recv_idle;
	bit                   hold_off = 0;
	int                   quiet = 0;
	int                   fill_pts;
	logic signed [31:0]   near_x [$];

	localparam int WATCHDOG = 200000;

	always #10 clk = ~clk;

	spatial_hash_grid_neighbor_search_core uut (.*);

	spatial_hash_grid_neighbor_search_checker chk (.*);

	always @(posedge clk) begin
		if (hold_off) out_stall <= 1;
		else out_stall <= ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > WATCHDOG) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send(op_t op, logic [31:0] x, logic [31:0] y, logic [30:0] r);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= '{op, x, y, r};
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [30:0] val);
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (5000) @(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [31:0] rand_coord(logic [30:0] sp);
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(8 * sp)) - $signed(4 * sp);
			default: return near_x.size() ? near_x[$urandom_range(near_x.size() - 1)]
				+ $signed($urandom_range(2 * sp)) - $signed(sp) : $urandom;
		endcase
	endfunction

	task automatic random_phase(int count, logic [30:0] sp);
		logic [31:0] x, y;
		op_t op;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(19))
				0: op = OP_CLEAR;
				1, 2, 3, 4, 5, 6, 7, 8, 9: op = OP_ADD;
				10, 11, 12, 13, 14: op = OP_QUERY_ALL;
				default: op = OP_QUERY_ANY;
			endcase
			x = rand_coord(sp);
			y = rand_coord(sp);
			if (op == OP_ADD) begin
				near_x = {near_x, x};
				near_x = {near_x, y};
			end
			send(op, x, y, ($urandom_range(3) == 0) ? $urandom : $urandom_range(2 * sp));
		end
	endtask

	initial begin
		send_idle = 19;
		recv_idle = 74;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send(OP_QUERY_ALL, 0, 0, 31'h7fffffff);
		send(OP_ADD, 32'h7fffffff, 32'h7fffffff, 0);
		send(OP_ADD, 32'h80000000, 32'h80000000, 0);
		send(OP_ADD, 0, 0, 5);
		send(OP_ADD, 32'h8000, 32'hffff8000, 0);
		send(OP_QUERY_ALL, 32'h4000, 0, 31'h10000);
		send(OP_QUERY_ANY, 32'hc000, 32'hc000, 31'h10000);
		send(OP_QUERY_ANY, 32'h40000000, 0, 1);
		send(OP_QUERY_ALL, 32'h7fffffff, 32'h7fffffff, 0);
		for (int i = 0; i < 17; i++) send(OP_ADD, 32'h100 * i, 32'h200, 0);
		send(OP_QUERY_ALL, 32'h800, 32'h200, 31'h7fffffff);
		send(OP_CLEAR, $urandom, $urandom, $urandom);

		// many hits from one bucket searched under all four keys
		write_reg(REG_RESOLUTION_X, 1);
		write_reg(REG_RESOLUTION_Y, 1);
		for (int i = 0; i < 16; i++) send(OP_ADD, i, -i, 0);
		send(OP_QUERY_ALL, 0, 0, 100);
		send(OP_QUERY_ANY, 0, 0, 0);

		fork
			begin
				hold_off <= 1;
				repeat (2000) @(posedge clk);
				hold_off <= 0;
			end
		join_none
		for (int i = 0; i < 6; i++) send(OP_QUERY_ANY, $urandom, $urandom, $urandom);

		write_reg(REG_RESOLUTION_X, 64);
		write_reg(REG_RESOLUTION_Y, 64);
		send(OP_CLEAR, 0, 0, 0);
		send_idle = 0;
		recv_idle = 0;
		fill_pts = 0;
		for (int bx = 0; fill_pts < 48; bx++)
			for (int k = 0; k < 16 && fill_pts < 48; k++, fill_pts++)
				send(OP_ADD, bx << 16, (bx / 64) << 16, 0);
		send(OP_QUERY_ANY, 0, 0, 31'h7fffffff);
		send(OP_CLEAR, 0, 0, 0);

		send_idle = 74;
		recv_idle = 19;
		write_reg(REG_GRID_SPACING, 0);
		write_reg(REG_RESOLUTION_X, 0);
		write_reg(REG_RESOLUTION_Y, 127);
		random_phase(80, 4);

		send_idle = 19;
		recv_idle = 74;
		write_reg(REG_GRID_SPACING, 31'h7fffffff);
		write_reg(REG_RESOLUTION_X, 3);
		write_reg(REG_RESOLUTION_Y, 2);
		random_phase(80, 31'h10000000);

		send_idle = 74;
		recv_idle = 19;
		write_reg(REG_GRID_SPACING, 31'h4000);
		write_reg(REG_RESOLUTION_X, 5);
		write_reg(REG_RESOLUTION_Y, 64);
		random_phase(160, 31'h4000);

		send_idle = 0;
		recv_idle = 0;
		write_reg(REG_GRID_SPACING, 31'h10000);
		write_reg(REG_RESOLUTION_X, 64);
		write_reg(REG_RESOLUTION_Y, 7);
		random_phase(100, 31'h10000);

		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (5000) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
